[src/srtf_pkg.sv]
// ----------------------------------------------------------------------------
// srtf_pkg
// Shared types and constants of the shortest-remaining-time-first scheduler.
// ----------------------------------------------------------------------------
package srtf_pkg;

  localparam int FIELD_W  = 16;
  localparam int TIME_W   = 32;
  localparam int STATUS_W = 3;
  localparam int PNUM_W   = 5;

  localparam logic [STATUS_W-1:0] ST_LOADED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_IDLE   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RAN    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_DONE   = 3'd5;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_FULL,
    OP_ZERO,
    OP_TICK
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [FIELD_W-1:0] arrival;
    logic [FIELD_W-1:0] burst;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PNUM_W-1:0]   process_number;
    logic [TIME_W-1:0]   slot_time;
    logic [TIME_W-1:0]   completion_time;
    logic [TIME_W-1:0]   turnaround_time;
    logic [TIME_W-1:0]   waiting_time;
    logic                all_done;
  } res_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN,
    BK_UPDATE,
    BK_FINISH,
    BK_EMIT
  } bk_state_t;

endpackage

[src/srtf_front.sv]
// ----------------------------------------------------------------------------
// srtf_front
// Takes input words and classifies adds as load, table full or zero burst.
// ----------------------------------------------------------------------------
module srtf_front import srtf_pkg::*; #(
  parameter int MAX_PROCS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               kind,
  input  logic [FIELD_W-1:0] arrival_time,
  input  logic [FIELD_W-1:0] burst_time,
  input  logic               q_full,
  output logic               q_push,
  output cmd_t               q_cmd
);

  localparam int CNT_W = $clog2(MAX_PROCS + 1);

  // number of loads sent on; decides the full check ahead of the back end
  logic [CNT_W-1:0] count;

  assign q_push = push && !q_full;

  always_comb begin
    q_cmd.arrival = arrival_time;
    q_cmd.burst   = burst_time;
    priority if (kind) begin
      q_cmd.op = OP_TICK;
    end else if (32'(count) >= MAX_PROCS) begin
      q_cmd.op = OP_FULL;
    end else if (burst_time == '0) begin
      q_cmd.op = OP_ZERO;
    end else begin
      q_cmd.op = OP_LOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (q_push && q_cmd.op == OP_LOAD) begin
      count <= count + 1'b1;
    end
  end

endmodule

[src/srtf_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// srtf_cmd_fifo
// Two-entry command queue between the front and back ends.
// ----------------------------------------------------------------------------
module srtf_cmd_fifo import srtf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_data,
  output logic full,
  input  logic rd_en,
  output cmd_t rd_data,
  output logic empty
);

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;

  assign full    = (cnt == 2'd2);
  assign empty   = (cnt == 2'd0);
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({wr_en, rd_en})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

[src/srtf_back.sv]
// ----------------------------------------------------------------------------
// srtf_back
// Process table, minimum remaining time scan, update and result register.
// ----------------------------------------------------------------------------
module srtf_back import srtf_pkg::*; #(
  parameter int MAX_PROCS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_pop,
  output res_t res,
  output logic res_valid,
  input  logic res_pop
);

  localparam int CNT_W = $clog2(MAX_PROCS + 1);
  localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int WORD_W = 3 * FIELD_W;

  bk_state_t state;
  bk_state_t state_next;

  // table word: arrival, burst, remaining
  logic [WORD_W-1:0] mem [MAX_PROCS];
  logic [WORD_W-1:0] rd_data;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic              mem_we;

  logic [CNT_W-1:0]   loaded_count;
  logic [CNT_W-1:0]   completed_count;
  logic [TIME_W-1:0]  current_time;
  logic [TIME_W-1:0]  time_inc;
  logic [TIME_W-1:0]  slot;
  logic [CNT_W-1:0]   issue_idx;
  logic [IDX_W-1:0]   eval_idx;
  logic               pend;
  logic               found;
  logic [IDX_W-1:0]   best_idx;
  logic [FIELD_W-1:0] best_arr;
  logic [FIELD_W-1:0] best_bur;
  logic [FIELD_W-1:0] best_rem;
  logic [TIME_W-1:0]  comp;
  logic [TIME_W-1:0]  tat;
  res_t               pend_res;

  logic               scan_issue;
  logic               emit_go;
  logic               eligible;
  logic [FIELD_W-1:0] rd_arr;
  logic [FIELD_W-1:0] rd_bur;
  logic [FIELD_W-1:0] rd_rem;
  logic [PNUM_W-1:0]  best_pnum;

  assign rd_arr    = rd_data[WORD_W-1 -: FIELD_W];
  assign rd_bur    = rd_data[2*FIELD_W-1 -: FIELD_W];
  assign rd_rem    = rd_data[FIELD_W-1:0];
  assign time_inc  = (current_time == '1) ? current_time : current_time + 1'b1;
  assign best_pnum = PNUM_W'(32'(best_idx) + 32'd1);
  assign rd_addr   = issue_idx[IDX_W-1:0];

  assign eligible = pend && (TIME_W'(rd_arr) <= current_time) && (rd_rem != '0) &&
                    (!found || rd_rem < best_rem);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (cmd_valid) begin
          state_next = (cmd.op == OP_TICK) ? BK_SCAN : BK_EMIT;
        end
      end
      BK_SCAN: begin
        if (!scan_issue && !pend) begin
          state_next = BK_UPDATE;
        end
      end
      BK_UPDATE: state_next = (found && best_rem == 16'd1) ? BK_FINISH : BK_EMIT;
      BK_FINISH: state_next = BK_EMIT;
      BK_EMIT: begin
        if (emit_go) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    cmd_pop    = 1'b0;
    scan_issue = 1'b0;
    emit_go    = 1'b0;
    mem_we     = 1'b0;
    wr_addr    = loaded_count[IDX_W-1:0];
    wr_data    = {cmd.arrival, cmd.burst, cmd.burst};
    unique case (state)
      BK_IDLE: begin
        cmd_pop = cmd_valid;
        mem_we  = cmd_valid && (cmd.op == OP_LOAD);
      end
      BK_SCAN:   scan_issue = (issue_idx < loaded_count);
      BK_UPDATE: begin
        mem_we  = found;
        wr_addr = best_idx;
        wr_data = {best_arr, best_bur, best_rem - 1'b1};
      end
      BK_FINISH: ;
      BK_EMIT:   emit_go = !res_valid || res_pop;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (emit_go) begin
      res <= pend_res;
    end
    unique case (state)
      BK_IDLE: begin
        slot     <= current_time;
        eval_idx <= '0;
        pend_res.slot_time       <= current_time;
        pend_res.completion_time <= '0;
        pend_res.turnaround_time <= '0;
        pend_res.waiting_time    <= '0;
        pend_res.process_number  <= (cmd.op == OP_LOAD) ?
                                    PNUM_W'(32'(loaded_count) + 32'd1) : '0;
        pend_res.all_done        <= (cmd.op == OP_LOAD) ?
                                    (completed_count == loaded_count + 1'b1) :
                                    (completed_count == loaded_count);
        unique case (cmd.op)
          OP_LOAD: pend_res.status <= ST_LOADED;
          OP_FULL: pend_res.status <= ST_FULL;
          OP_ZERO: pend_res.status <= ST_ZERO;
          OP_TICK: pend_res.status <= ST_IDLE;
          default: pend_res.status <= ST_IDLE;
        endcase
      end
      BK_SCAN: begin
        eval_idx <= issue_idx[IDX_W-1:0];
        if (eligible) begin
          best_idx <= eval_idx;
          best_arr <= rd_arr;
          best_bur <= rd_bur;
          best_rem <= rd_rem;
        end
      end
      BK_UPDATE: begin
        comp <= time_inc;
        tat  <= time_inc - TIME_W'(best_arr);
        pend_res.status         <= !found ? ST_IDLE : ST_RAN;
        pend_res.process_number <= found ? best_pnum : '0;
        pend_res.all_done       <= (completed_count == loaded_count);
      end
      BK_FINISH: begin
        pend_res.status          <= ST_DONE;
        pend_res.process_number  <= best_pnum;
        pend_res.slot_time       <= slot;
        pend_res.completion_time <= comp;
        pend_res.turnaround_time <= tat;
        pend_res.waiting_time    <= (tat >= TIME_W'(best_bur)) ? tat - TIME_W'(best_bur) : '0;
        pend_res.all_done        <= (completed_count == loaded_count);
      end
      BK_EMIT: ;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= BK_IDLE;
      loaded_count    <= '0;
      completed_count <= '0;
      current_time    <= '0;
      issue_idx       <= '0;
      pend            <= 1'b0;
      found           <= 1'b0;
      res_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (emit_go) begin
        res_valid <= 1'b1;
      end else if (res_pop) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        BK_IDLE: begin
          issue_idx <= '0;
          pend      <= 1'b0;
          found     <= 1'b0;
          if (mem_we) begin
            loaded_count <= loaded_count + 1'b1;
          end
        end
        BK_SCAN: begin
          pend <= scan_issue;
          if (scan_issue) begin
            issue_idx <= issue_idx + 1'b1;
          end
          if (eligible) begin
            found <= 1'b1;
          end
        end
        BK_UPDATE: begin
          current_time <= time_inc;
          if (found && best_rem == 16'd1) begin
            completed_count <= completed_count + 1'b1;
          end
        end
        BK_FINISH: ;
        BK_EMIT: ;
        default: ;
      endcase
    end
  end

endmodule

[src/srtf_preemptive_scheduler.sv]
// ----------------------------------------------------------------------------
// srtf_preemptive_scheduler
// Preemptive shortest-remaining-time-first scheduler with queue-style ports.
// ----------------------------------------------------------------------------
// an add word goes through the queue to the back end, which moves from idle to emit;
// a tick moves from idle through scan and update (and finish when the process
// finishes) to emit; emit holds until the result register is free or popped; the
// back end takes the next word only after it returns to idle; a two-word queue
// decouples the input side; the scan reads one table entry a cycle through a single
// read port; reset clears counts, time, queue and result valid
module srtf_preemptive_scheduler import srtf_pkg::*; #(
  parameter int MAX_PROCS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic                kind,
  input  logic [FIELD_W-1:0]  arrival_time,
  input  logic [FIELD_W-1:0]  burst_time,
  output logic                empty,
  input  logic                pop,
  output logic [STATUS_W-1:0] status,
  output logic [PNUM_W-1:0]   process_number,
  output logic [TIME_W-1:0]   slot_time,
  output logic [TIME_W-1:0]   completion_time,
  output logic [TIME_W-1:0]   turnaround_time,
  output logic [TIME_W-1:0]   waiting_time,
  output logic                all_done
);

  logic q_push;
  logic q_full;
  logic q_empty;
  logic q_pop;
  cmd_t q_wr_cmd;
  cmd_t q_rd_cmd;
  res_t res;
  logic res_valid;

  assign full  = q_full;
  assign empty = !res_valid;

  srtf_front #(
    .MAX_PROCS(MAX_PROCS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .kind        (kind),
    .arrival_time(arrival_time),
    .burst_time  (burst_time),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (q_wr_cmd)
  );

  srtf_cmd_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (q_push),
    .wr_data(q_wr_cmd),
    .full   (q_full),
    .rd_en  (q_pop),
    .rd_data(q_rd_cmd),
    .empty  (q_empty)
  );

  srtf_back #(
    .MAX_PROCS(MAX_PROCS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(!q_empty),
    .cmd      (q_rd_cmd),
    .cmd_pop  (q_pop),
    .res      (res),
    .res_valid(res_valid),
    .res_pop  (pop && res_valid)
  );

  assign status          = res.status;
  assign process_number  = res.process_number;
  assign slot_time       = res.slot_time;
  assign completion_time = res.completion_time;
  assign turnaround_time = res.turnaround_time;
  assign waiting_time    = res.waiting_time;
  assign all_done        = res.all_done;

endmodule

[tb/tb_srtf_preemptive_scheduler.sv]
// ----------------------------------------------------------------------------
// tb_srtf_preemptive_scheduler
// Self-checking bench for the shortest-remaining-time-first scheduler. A
// word-level predictor keeps its own process table, counters and clock,
// computes the result word for every accepted input word, and checks each
// popped word field by field. Both queue sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_srtf_preemptive_scheduler;
  import srtf_pkg::*;

  localparam int   MAX_PROCS = 16;
  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  logic                clk;
  logic                rst;
  logic                push;
  logic                full;
  logic                kind;
  logic [FIELD_W-1:0]  arrival_time;
  logic [FIELD_W-1:0]  burst_time;
  logic                empty;
  logic                pop;
  logic [STATUS_W-1:0] status;
  logic [PNUM_W-1:0]   process_number;
  logic [TIME_W-1:0]   slot_time;
  logic [TIME_W-1:0]   completion_time;
  logic [TIME_W-1:0]   turnaround_time;
  logic [TIME_W-1:0]   waiting_time;
  logic                all_done;

  // predictor copy of the scheduler state
  logic [FIELD_W-1:0] arr_tbl [MAX_PROCS];
  logic [FIELD_W-1:0] bur_tbl [MAX_PROCS];
  logic [FIELD_W-1:0] rem_tbl [MAX_PROCS];
  int                 n_loaded;
  int                 n_done;
  logic [TIME_W-1:0]  now_time;

  res_t due_words[$];
  int   mismatch_count;
  int   sent_count;
  int   status_seen [8];
  bit   no_gaps;
  int   rx_hold;

  srtf_preemptive_scheduler #(.MAX_PROCS(MAX_PROCS)) DUT (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .kind           (kind),
    .arrival_time   (arrival_time),
    .burst_time     (burst_time),
    .empty          (empty),
    .pop            (pop),
    .status         (status),
    .process_number (process_number),
    .slot_time      (slot_time),
    .completion_time(completion_time),
    .turnaround_time(turnaround_time),
    .waiting_time   (waiting_time),
    .all_done       (all_done)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic res_t schedule_step(input logic k, input logic [FIELD_W-1:0] a,
                                         input logic [FIELD_W-1:0] b);
    res_t              r;
    int                best;
    bit                found;
    logic [TIME_W-1:0] tat;
    r = '0;
    r.slot_time = now_time;
    found = 1'b0;
    best = 0;
    if (k == KIND_ADD) begin
      if (n_loaded >= MAX_PROCS) begin
        r.status = ST_FULL;
      end else if (b == '0) begin
        r.status = ST_ZERO;
      end else begin
        arr_tbl[n_loaded] = a;
        bur_tbl[n_loaded] = b;
        rem_tbl[n_loaded] = b;
        n_loaded++;
        r.status = ST_LOADED;
        r.process_number = PNUM_W'(n_loaded);
      end
    end else begin
      // least remaining among arrived work, lowest slot on a tie
      for (int i = 0; i < n_loaded; i++) begin
        if (TIME_W'(arr_tbl[i]) <= now_time && rem_tbl[i] != '0 &&
            (!found || rem_tbl[i] < rem_tbl[best])) begin
          found = 1'b1;
          best = i;
        end
      end
      if (now_time != '1) now_time++;
      if (!found) begin
        r.status = ST_IDLE;
      end else begin
        rem_tbl[best]--;
        r.process_number = PNUM_W'(best + 1);
        if (rem_tbl[best] == '0) begin
          tat = now_time - TIME_W'(arr_tbl[best]);
          r.status = ST_DONE;
          r.completion_time = now_time;
          r.turnaround_time = tat;
          r.waiting_time = (tat >= TIME_W'(bur_tbl[best])) ? tat - TIME_W'(bur_tbl[best]) : '0;
          n_done++;
        end else begin
          r.status = ST_RAN;
        end
      end
    end
    r.all_done = (n_done == n_loaded);
    return r;
  endfunction

  task automatic send_word(input logic k, input logic [FIELD_W-1:0] a,
                           input logic [FIELD_W-1:0] b);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    kind <= k;
    arrival_time <= a;
    burst_time <= b;
    do @(posedge clk); while (full);
    due_words.push_back(schedule_step(k, a, b));
    sent_count++;
  endtask

  // tick fields are don't-care, keep them random
  task automatic send_ticks(input int n);
    for (int i = 0; i < n; i++) send_word(KIND_TICK, 16'($urandom), 16'($urandom));
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [TIME_W-1:0] exp_v,
                             input logic [TIME_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  task automatic check_word();
    res_t w;
    if (due_words.size() == 0) begin
      $error("word popped with nothing due: status %0d", status);
      mismatch_count++;
      return;
    end
    w = due_words.pop_front();
    if (!$isunknown(status)) status_seen[status]++;
    check_field("status", TIME_W'(w.status), TIME_W'(status));
    check_field("process_number", TIME_W'(w.process_number), TIME_W'(process_number));
    check_field("slot_time", w.slot_time, slot_time);
    check_field("completion_time", w.completion_time, completion_time);
    check_field("turnaround_time", w.turnaround_time, turnaround_time);
    check_field("waiting_time", w.waiting_time, waiting_time);
    check_field("all_done", TIME_W'(w.all_done), TIME_W'(all_done));
  endtask

  // result side: check on accept, then draw the next stall
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      rx_hold = 0;
    end else begin
      if (pop && !empty) begin
        check_word();
        rx_hold = no_gaps ? 0 : $urandom_range(0, 9);
      end
      if (rx_hold > 0) begin
        rx_hold--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic test_empty_table();
    send_ticks(2);
    send_word(KIND_ADD, 16'd0, 16'd0);
    send_word(KIND_ADD, 16'hFFFF, 16'd0);
  endtask

  // tie goes to the lower slot, a shorter arrival preempts
  task automatic test_tie_and_preempt();
    send_word(KIND_ADD, 16'(now_time), 16'd2);
    send_word(KIND_ADD, 16'(now_time + 1), 16'd1);
    send_ticks(3);
    send_word(KIND_ADD, 16'(now_time), 16'd3);
    send_ticks(1);
    send_word(KIND_ADD, 16'(now_time), 16'd1);
    send_ticks(4);
  endtask

  task automatic test_late_arrival();
    no_gaps = 1'b1;
    send_word(KIND_ADD, 16'd0, 16'd2);
    send_ticks(2);
    no_gaps = 1'b0;
  endtask

  // processes that never become eligible during the run
  task automatic test_field_extremes();
    send_word(KIND_ADD, 16'hFFFF, 16'hFFFF);
    send_word(KIND_ADD, 16'h8000, 16'h0001);
    wait_drained();
    send_ticks(2);
  endtask

  task automatic test_random_mix(input int n);
    logic [FIELD_W-1:0] a;
    logic [FIELD_W-1:0] b;
    int                 pick;
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 5) begin
        pick = $urandom_range(0, 9);
        b = 16'($urandom_range(1, 12));
        if (pick < 6) begin
          a = 16'(now_time) + 16'($urandom_range(0, 15));
        end else if (pick < 8) begin
          a = (now_time > 30) ? 16'(now_time - $urandom_range(1, 30)) : '0;
        end else begin
          a = 16'($urandom);
          b = 16'($urandom);
        end
        if ($urandom_range(0, 7) == 0) b = '0;
        send_word(KIND_ADD, a, b);
      end else begin
        send_word(KIND_TICK, 16'($urandom), 16'($urandom));
      end
    end
    no_gaps = 1'b0;
  endtask

  // full check wins over a zero burst
  task automatic test_full_table();
    while (n_loaded < MAX_PROCS)
      send_word(KIND_ADD, 16'(now_time), 16'($urandom_range(1, 4)));
    send_word(KIND_ADD, 16'd0, 16'd0);
    send_word(KIND_ADD, 16'($urandom), 16'hFFFF);
    send_ticks(30);
  endtask

  initial begin
    rst = 1'b1;
    push = 1'b0;
    kind = KIND_ADD;
    arrival_time = '0;
    burst_time = '0;
    pop = 1'b0;
    no_gaps = 1'b0;
    n_loaded = 0;
    n_done = 0;
    now_time = '0;
    mismatch_count = 0;
    sent_count = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_table();
    test_tie_and_preempt();
    test_late_arrival();
    test_field_extremes();
    test_random_mix(500);
    test_full_table();

    wait_drained();
    repeat (40) @(posedge clk);
    $display("run covered %0d words, %0d processes loaded, %0d finished", sent_count,
             n_loaded, n_done);
    $display("status mix: %0d loaded %0d full %0d zero %0d idle %0d ran %0d finished",
             status_seen[ST_LOADED], status_seen[ST_FULL], status_seen[ST_ZERO],
             status_seen[ST_IDLE], status_seen[ST_RAN], status_seen[ST_DONE]);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
